### rtl/mqts_pkg.sv
// ----------------------------------------------------------------------------
// mqts_pkg: shared types and constants of the min queue
// Operation and error codes, default sizes and the command queue depth.
// ----------------------------------------------------------------------------
`default_nettype none

package mqts_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int CMDQ_DEPTH         = 2;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_POP_EMPTY = 2'd1,
      ERR_PUSH_FULL = 2'd2
   } err_type;

endpackage

`default_nettype wire

### rtl/mqts_if.sv
// ----------------------------------------------------------------------------
// mqts_req_if / mqts_rsp_if: request and response channels
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqts_req_if
   import mqts_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mqts_rsp_if
   import mqts_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int CNT_WIDTH  = $clog2(DEPTH_DEFAULT + 1)
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] front_value;
   logic signed [DATA_WIDTH-1:0] min_value;
   logic [CNT_WIDTH-1:0]         count;
   logic                         is_empty;
   logic [1:0]                   error;

   modport source (output valid, output front_value, output min_value, output count,
                   output is_empty, output error, input ready);
   modport sink   (input valid, input front_value, input min_value, input count,
                   input is_empty, input error, output ready);
endinterface

`default_nettype wire

### rtl/mqts_front.sv
// ----------------------------------------------------------------------------
// mqts_front: request intake and classification
// Tracks the element count and tags each item as a push, a pop, or a
// rejected operation before it enters the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mqts_front
   import mqts_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int CMD_WIDTH  = DATA_WIDTH + 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   mqts_req_if.sink                  req_chan,
   input  wire logic                 cmd_full,
   output logic                      cmd_push,
   output logic [CMD_WIDTH-1:0]      cmd_data
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef struct packed {
      op_type                op;
      err_type               err;
      logic [DATA_WIDTH-1:0] value;
   } cmd_type;

   logic [CW-1:0] total_ff;
   logic [CW-1:0] total_in;
   cmd_type       cmd;
   logic          accept;

   assign req_chan.ready = !cmd_full;
   assign accept         = req_chan.valid && !cmd_full;

   always_comb begin
      cmd.op    = op_type'(req_chan.mode);
      cmd.value = req_chan.value;
      cmd.err   = ERR_NONE;
      total_in  = total_ff;
      if (cmd.op == OP_PUSH) begin
         if (total_ff == CW'(DEPTH)) begin
            cmd.err = ERR_PUSH_FULL;
         end else begin
            total_in = total_ff + 1'b1;
         end
      end else begin
         if (total_ff == '0) begin
            cmd.err = ERR_POP_EMPTY;
         end else begin
            total_in = total_ff - 1'b1;
         end
      end
   end

   assign cmd_push = accept;
   assign cmd_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (accept) begin
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

### rtl/mqts_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mqts_cmd_fifo: command queue between intake and execution
// A small register FIFO so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mqts_cmd_fifo
   import mqts_pkg::*;
#(
   parameter int WIDTH = DATA_WIDTH_DEFAULT + 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int NW = $clog2(CMDQ_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [CMDQ_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [NW-1:0]    fill_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (fill_ff == NW'(CMDQ_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      return (ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/mqts_back.sv
// ----------------------------------------------------------------------------
// mqts_back: stack engine and result register
// Holds the input and output stacks in memories, moves the input stack over
// one element at a time when a pop finds the output stack empty, and builds
// the result item from the stack tops kept in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mqts_back
   import mqts_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int CMD_WIDTH  = DATA_WIDTH + 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire logic [CMD_WIDTH-1:0] cmd_data,
   output logic                      cmd_pop,
   mqts_rsp_if.source                rsp_chan
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int DW = DATA_WIDTH;

   typedef struct packed {
      op_type        op;
      err_type       err;
      logic [DW-1:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN_RD,
      ST_DRAIN_WR,
      ST_POP_RD,
      ST_POP_WR
   } state_type;

   function automatic logic [DW-1:0] smin(input logic [DW-1:0] a, input logic [DW-1:0] b);
      return ($signed(b) < $signed(a)) ? b : a;
   endfunction

   // Stack memories; the output stack stores each value with its running minimum.
   logic [DW-1:0]   in_mem  [DEPTH];
   logic [2*DW-1:0] out_mem [DEPTH];
   logic [DW-1:0]   in_rd_ff;
   logic [2*DW-1:0] out_rd_ff;

   logic            in_we;
   logic [AW-1:0]   in_waddr;
   logic [AW-1:0]   in_raddr;
   logic            out_we;
   logic [AW-1:0]   out_waddr;
   logic [AW-1:0]   out_raddr;
   logic [2*DW-1:0] out_wdata;

   state_type     state_ff, state_in;
   logic [CW-1:0] in_count_ff, in_count_in;
   logic [CW-1:0] out_count_ff, out_count_in;
   logic [DW-1:0] in_bottom_ff, in_bottom_in;
   logic [DW-1:0] in_min_ff, in_min_in;
   logic [DW-1:0] out_top_val_ff, out_top_val_in;
   logic [DW-1:0] out_top_min_ff, out_top_min_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_front_ff, rsp_front_in;
   logic [DW-1:0] rsp_min_ff, rsp_min_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_empty_ff, rsp_empty_in;
   err_type       rsp_error_ff, rsp_error_in;

   cmd_type       cmd;
   logic          rsp_free;
   logic          finish;
   err_type       fin_err;
   logic          in_ne;
   logic          out_ne;
   logic [CW-1:0] sub_one;
   logic [CW-1:0] sub_two;
   logic [DW-1:0] drain_min;

   assign cmd      = cmd_type'(cmd_data);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign sub_one   = in_count_ff - 1'b1;
   assign sub_two   = out_count_ff - CW'(2);
   assign in_raddr  = sub_one[AW-1:0];
   assign out_raddr = sub_two[AW-1:0];
   assign in_waddr  = in_count_ff[AW-1:0];
   assign out_waddr = out_count_ff[AW-1:0];
   assign drain_min = (out_count_ff == '0) ? in_rd_ff : smin(in_rd_ff, out_top_min_ff);

   always_comb begin
      state_in       = state_ff;
      in_count_in    = in_count_ff;
      out_count_in   = out_count_ff;
      in_bottom_in   = in_bottom_ff;
      in_min_in      = in_min_ff;
      out_top_val_in = out_top_val_ff;
      out_top_min_in = out_top_min_ff;
      in_we          = 1'b0;
      out_we         = 1'b0;
      out_wdata      = {in_rd_ff, drain_min};
      cmd_pop        = 1'b0;
      finish         = 1'b0;
      fin_err        = ERR_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && rsp_free) begin
               cmd_pop = 1'b1;
               if (cmd.err != ERR_NONE) begin
                  finish  = 1'b1;
                  fin_err = cmd.err;
               end else if (cmd.op == OP_PUSH) begin
                  in_we       = 1'b1;
                  in_count_in = in_count_ff + 1'b1;
                  finish      = 1'b1;
                  if (in_count_ff == '0) begin
                     in_min_in    = cmd.value;
                     in_bottom_in = cmd.value;
                  end else begin
                     in_min_in = smin(cmd.value, in_min_ff);
                  end
               end else if (out_count_ff != '0) begin
                  state_in = ST_POP_RD;
               end else begin
                  state_in = ST_DRAIN_RD;
               end
            end
         end
         ST_DRAIN_RD: begin
            // The read of the input stack top is issued at this edge.
            in_count_in = sub_one;
            state_in    = ST_DRAIN_WR;
         end
         ST_DRAIN_WR: begin
            out_we         = 1'b1;
            out_top_val_in = in_rd_ff;
            out_top_min_in = drain_min;
            out_count_in   = out_count_ff + 1'b1;
            state_in       = (in_count_ff == '0) ? ST_POP_RD : ST_DRAIN_RD;
         end
         ST_POP_RD: begin
            if (out_count_ff == CW'(1)) begin
               out_count_in = '0;
               finish       = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_POP_WR;
            end
         end
         ST_POP_WR: begin
            out_top_val_in = out_rd_ff[2*DW-1:DW];
            out_top_min_in = out_rd_ff[DW-1:0];
            out_count_in   = out_count_ff - 1'b1;
            finish         = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result fields come from the state as it stands after the operation.
   always_comb begin
      in_ne        = (in_count_in != '0);
      out_ne       = (out_count_in != '0);
      rsp_count_in = in_count_in + out_count_in;
      rsp_empty_in = !in_ne && !out_ne;
      rsp_error_in = fin_err;
      if (out_ne) begin
         rsp_front_in = out_top_val_in;
      end else if (in_ne) begin
         rsp_front_in = in_bottom_in;
      end else begin
         rsp_front_in = '0;
      end
      if (in_ne && out_ne) begin
         rsp_min_in = smin(in_min_in, out_top_min_in);
      end else if (out_ne) begin
         rsp_min_in = out_top_min_in;
      end else if (in_ne) begin
         rsp_min_in = in_min_in;
      end else begin
         rsp_min_in = '0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_we) begin
         in_mem[in_waddr] <= cmd.value;
      end
      in_rd_ff <= in_mem[in_raddr];
   end

   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[out_waddr] <= out_wdata;
      end
      out_rd_ff <= out_mem[out_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_count_ff  <= '0;
         out_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_bottom_ff   <= in_bottom_in;
      in_min_ff      <= in_min_in;
      out_top_val_ff <= out_top_val_in;
      out_top_min_ff <= out_top_min_in;
      if (finish) begin
         rsp_front_ff <= rsp_front_in;
         rsp_min_ff   <= rsp_min_in;
         rsp_count_ff <= rsp_count_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.min_value   = rsp_min_ff;
   assign rsp_chan.count       = rsp_count_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.error       = rsp_error_ff;

endmodule

`default_nettype wire

### rtl/min_queue_two_stacks_core.sv
// ----------------------------------------------------------------------------
// min_queue_two_stacks_core: FIFO queue that reports the minimum it holds
// Each request item either pushes a signed value or pops the oldest one.
// Every request gives exactly one response item with the oldest value, the
// minimum of all held values (both zero when empty), the count, an empty
// flag and an error code (pop on empty or push on full is ignored).
// The request channel feeds a classifier that keeps the element count and
// writes commands into a two-entry queue; the stack engine behind it runs
// them and parks each response in an output register.
// A push or a rejected item finishes as soon as the engine takes it. A
// pop reads the output stack when that stack holds elements, and when it is
// empty first moves all N elements of the input stack over, one element at a
// time through the input stack memory read port. Each element is pushed,
// moved and popped once; the engine takes a further command from the queue
// only after it has finished the current one.
// Reset empties both stacks at once; no clearing pass is needed.
// When the receiver holds off the response, the engine finishes no further
// item; the command queue fills and then the request channel stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module min_queue_two_stacks_core
   import mqts_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mqts_req_if.sink   req_chan,
   mqts_rsp_if.source rsp_chan
);

   localparam int CMD_WIDTH = DATA_WIDTH + 3;

   logic                 cmd_full;
   logic                 cmd_push;
   logic [CMD_WIDTH-1:0] cmd_wdata;
   logic                 cmd_valid;
   logic                 cmd_pop;
   logic [CMD_WIDTH-1:0] cmd_rdata;

   mqts_front #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CMD_WIDTH  (CMD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wdata)
   );

   mqts_cmd_fifo #(
      .WIDTH (CMD_WIDTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .pop_data  (cmd_rdata)
   );

   mqts_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CMD_WIDTH  (CMD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
